FILE: rtl/core/mtt_pkg.sv
// Shared types and codes for the multi-channel tick timer.
// Used by mtt_cell and multi_channel_tick_timer_top; depends on nothing.
package mtt_pkg;

	typedef enum logic [2:0] {
		OP_INIT    = 3'd0,
		OP_START   = 3'd1,
		OP_STOP    = 3'd2,
		OP_DESTROY = 3'd3,
		OP_INFO    = 3'd4,
		OP_TICK    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_UNUSED    = 3'd0,
		ST_CREATED   = 3'd1,
		ST_STARTED   = 3'd2,
		ST_STOPPED   = 3'd3,
		ST_DESTROYED = 3'd4
	} tstate_t;

	localparam logic [1:0] KIND_FIRED = 2'd0;
	localparam logic [1:0] KIND_ACK   = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// Command from the sequencer to one cell.
	typedef struct packed {
		logic wr;
		op_t  op;
		logic hard;
	} cell_cmd_t;

	// Walk token handed from cell to cell; grp is the group being served.
	typedef struct packed {
		logic valid;
		logic grp;
	} tok_t;

endpackage

FILE: rtl/core/mtt_cell.sv
// One timer entry of the chain: holds its state and counts, serves the walk
// token when it passes and hands the token on. Depends on mtt_pkg.
module mtt_cell #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  mtt_pkg::cell_cmd_t       cmd,
	input  logic [COUNT_WIDTH-1:0]   cmd_sd,
	input  logic [COUNT_WIDTH-1:0]   cmd_per,
	input  mtt_pkg::tok_t            tok_in,
	output mtt_pkg::tok_t            tok_out,
	output logic                     fire,
	output mtt_pkg::tstate_t         nxt_state,
	output logic [COUNT_WIDTH-1:0]   nxt_sd,
	output logic [COUNT_WIDTH-1:0]   nxt_per,
	output logic                     nxt_hard
);

	mtt_pkg::tstate_t       state_q;
	logic [COUNT_WIDTH-1:0] sd_q, per_q, rem_q, nxt_rem, dec;
	mtt_pkg::tok_t          tok_q;
	logic                   hard_q;
	logic                   serve;

	assign dec     = rem_q - COUNT_WIDTH'(1);
	assign serve   = tok_q.valid && adv && state_q == mtt_pkg::ST_STARTED
		&& hard_q == tok_q.grp;
	assign fire    = serve && (rem_q == '0 || dec == '0);
	assign tok_out = tok_q;

	always_comb begin
		nxt_state = state_q;
		nxt_sd    = sd_q;
		nxt_per   = per_q;
		nxt_hard  = hard_q;
		nxt_rem   = rem_q;
		if (serve) begin
			if (fire) begin
				if (per_q != '0) begin
					nxt_rem = per_q;
				end else begin
					nxt_state = mtt_pkg::ST_STOPPED;
				end
			end else begin
				nxt_rem = dec;
			end
		end
		if (cmd.wr) begin
			unique case (cmd.op)
				mtt_pkg::OP_INIT: begin
					nxt_sd    = cmd_sd;
					nxt_per   = cmd_per;
					nxt_hard  = cmd.hard;
					nxt_rem   = (cmd_sd != '0) ? cmd_sd : cmd_per;
					nxt_state = mtt_pkg::ST_CREATED;
				end
				mtt_pkg::OP_START: begin
					if (state_q == mtt_pkg::ST_CREATED || state_q == mtt_pkg::ST_STOPPED) begin
						nxt_rem   = (sd_q != '0) ? sd_q : per_q;
						nxt_state = mtt_pkg::ST_STARTED;
					end
				end
				mtt_pkg::OP_STOP: begin
					if (state_q == mtt_pkg::ST_STARTED) begin
						nxt_state = mtt_pkg::ST_STOPPED;
					end
				end
				mtt_pkg::OP_DESTROY: begin
					nxt_state = mtt_pkg::ST_DESTROYED;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtt_pkg::ST_UNUSED;
			sd_q    <= '0;
			per_q   <= '0;
			rem_q   <= '0;
			hard_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			state_q <= nxt_state;
			sd_q    <= nxt_sd;
			per_q   <= nxt_per;
			rem_q   <= nxt_rem;
			hard_q  <= nxt_hard;
			if (adv) begin
				tok_q <= tok_in;
			end
		end
	end

endmodule

FILE: rtl/core/multi_channel_tick_timer_top.sv
// Multi-channel tick timer: a chain of timer cells walked by a token, plus
// the op sequencer and the result register. Depends on mtt_pkg and mtt_cell.
//
//  channel | dir | tdata / tuser / tlast
//  s_      | in  | op, timer_index, start_delay, period, hard_kind
//  m_      | out | tuser result_kind; tdata timer..hard; tlast last
//
// An op other than tick goes through the S_OP state to its acknowledge item;
// an unknown op code is dropped with no item. A tick sends a token twice along
// the chain (hard group, then soft), one cell per cycle while not stalled.
// While the result register is full and not taken, the token stands still.
// Reset clears every entry to unused with zero counts; no input is taken
// until the previous item's results have all been loaded.
module multi_channel_tick_timer_top #(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] op, [6:3] timer_index, [38:7] start_delay, [70:39] period,
	// [71] hard_kind
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] result_timer, [6:4] info_state, [38:7] info_start_delay,
	// [70:39] info_period, [71] info_hard
	output logic [71:0] m_tdata,
	// [1:0] result_kind
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	typedef enum logic [2:0] {S_IDLE, S_OP, S_TSTART, S_WALK, S_DONE} seq_t;

	seq_t                   seq_q;
	logic                   adv, acc, ld_out;
	mtt_pkg::op_t           op_q;
	logic [3:0]             idx_q;
	logic [COUNT_WIDTH-1:0] sd_q, per_q;
	logic                   hard_q;

	logic                   ov_q;
	logic [1:0]             kind_q;
	logic [3:0]             tim_q;
	logic [2:0]             st_q;
	logic [31:0]            osd_q, oper_q;
	logic                   ohard_q, last_q;

	mtt_pkg::tok_t          tok [NUM_TIMERS];
	mtt_pkg::tok_t          tok_head;
	logic [NUM_TIMERS-1:0]  fire_v, tokv;
	mtt_pkg::tstate_t       n_st [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] n_sd [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] n_per [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  n_hard;

	logic                   any_fire;
	logic [3:0]             sel_tim;
	logic [2:0]             sel_st;
	logic [COUNT_WIDTH-1:0] sel_sd, sel_per;
	logic                   sel_hard;
	logic [NUM_TIMERS-1:0]  by_idx;

	assign adv      = !ov_q || m_tready;
	assign s_tready = seq_q == S_IDLE;
	assign acc      = s_tvalid && s_tready;
	// The result register takes a new item in this cycle.
	assign ld_out   = adv && (seq_q == S_OP || seq_q == S_DONE
		|| (seq_q == S_WALK && any_fire));

	// Token into the head of the chain: a fresh hard pass, or the soft pass
	// once the hard pass leaves the last cell.
	always_comb begin
		tok_head = '0;
		if (seq_q == S_TSTART) begin
			tok_head.valid = 1'b1;
			tok_head.grp   = 1'b1;
		end else if (seq_q == S_WALK && tok[NUM_TIMERS-1].valid && tok[NUM_TIMERS-1].grp) begin
			tok_head.valid = 1'b1;
			tok_head.grp   = 1'b0;
		end
	end

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		mtt_pkg::cell_cmd_t cmd;
		assign by_idx[i] = {26'd0, idx_q} == 30'(i);
		assign cmd.wr    = seq_q == S_OP && adv && by_idx[i];
		assign cmd.op    = op_q;
		assign cmd.hard  = hard_q;
		assign tokv[i]   = tok[i].valid;
		mtt_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cmd       (cmd),
			.cmd_sd    (sd_q),
			.cmd_per   (per_q),
			.tok_in    ((i == 0) ? tok_head : tok[(i == 0) ? 0 : i-1]),
			.tok_out   (tok[i]),
			.fire      (fire_v[i]),
			.nxt_state (n_st[i]),
			.nxt_sd    (n_sd[i]),
			.nxt_per   (n_per[i]),
			.nxt_hard  (n_hard[i])
		);
	end

	// Select the addressed cell for an op, the firing cell otherwise.
	always_comb begin
		logic [NUM_TIMERS-1:0] pick;
		pick     = (seq_q == S_OP) ? by_idx : fire_v;
		any_fire = |fire_v;
		sel_tim  = '0;
		sel_st   = '0;
		sel_sd   = '0;
		sel_per  = '0;
		sel_hard = 1'b0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (pick[i]) begin
				sel_tim  = sel_tim | 4'(i);
				sel_st   = sel_st | n_st[i];
				sel_sd   = sel_sd | n_sd[i];
				sel_per  = sel_per | n_per[i];
				sel_hard = sel_hard | n_hard[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= S_IDLE;
			ov_q    <= 1'b0;
			op_q    <= mtt_pkg::OP_INIT;
			idx_q   <= '0;
			sd_q    <= '0;
			per_q   <= '0;
			hard_q  <= 1'b0;
			kind_q  <= mtt_pkg::KIND_FIRED;
			tim_q   <= '0;
			st_q    <= '0;
			osd_q   <= '0;
			oper_q  <= '0;
			ohard_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (ld_out) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (seq_q)
				S_IDLE: begin
					if (acc) begin
						op_q   <= mtt_pkg::op_t'(s_tdata[2:0]);
						idx_q  <= s_tdata[6:3];
						sd_q   <= COUNT_WIDTH'(s_tdata[38:7]);
						per_q  <= COUNT_WIDTH'(s_tdata[70:39]);
						hard_q <= s_tdata[71];
						if (s_tdata[2:0] == mtt_pkg::OP_TICK) begin
							seq_q <= S_TSTART;
						end else if (s_tdata[2:0] <= mtt_pkg::OP_INFO) begin
							seq_q <= S_OP;
						end
					end
				end
				S_OP: begin
					if (adv) begin
						kind_q  <= mtt_pkg::KIND_ACK;
						tim_q   <= idx_q;
						st_q    <= sel_st;
						osd_q   <= 32'(sel_sd);
						oper_q  <= 32'(sel_per);
						ohard_q <= sel_hard;
						last_q  <= 1'b1;
						seq_q   <= S_IDLE;
					end
				end
				S_TSTART: begin
					if (adv) begin
						seq_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (adv) begin
						if (any_fire) begin
							kind_q  <= mtt_pkg::KIND_FIRED;
							tim_q   <= sel_tim;
							st_q    <= sel_st;
							osd_q   <= 32'(sel_sd);
							oper_q  <= 32'(sel_per);
							ohard_q <= sel_hard;
							last_q  <= 1'b0;
						end
						if (tok[NUM_TIMERS-1].valid && !tok[NUM_TIMERS-1].grp) begin
							seq_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (adv) begin
						kind_q  <= mtt_pkg::KIND_DONE;
						tim_q   <= '0;
						st_q    <= '0;
						osd_q   <= '0;
						oper_q  <= '0;
						ohard_q <= 1'b0;
						last_q  <= 1'b1;
						seq_q   <= S_IDLE;
					end
				end
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {ohard_q, oper_q, osd_q, st_q, tim_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tokv))
		else $error("more than one walk token in the chain");
	a_one_fire: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(fire_v))
		else $error("several cells fired in one cycle");
	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(|tokv))
		else $error("input taken while a walk is in progress");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == mtt_pkg::KIND_DONE) |-> m_tlast)
		else $error("tick-done item without last");

endmodule
